// ===== hw/rtl/triangle_unit_normal_unit_defines.svh =====
// Assertion macros used by the checker file of the triangle unit normal block.
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define TUN_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tun_pkg.sv =====
// Package with the widths, stage counts and the cross-product type of the unit normal block.
`default_nettype none
package tun_pkg;
    localparam int CoordW   = 24;
    localparam int EdgeW    = 25;
    localparam int ProdW    = 50;
    localparam int CrossW   = 50;
    localparam int MagW     = 49;
    localparam int GrpW     = 7;
    localparam int NumGrp   = 7;
    localparam int GposW    = 3;
    localparam int LenW     = 6;
    localparam int NormW    = 31;
    localparam int NormLsb  = MagW - NormW;
    localparam int SqrW     = 2 * NormW;
    localparam int SumW     = 64;
    localparam int RootW    = 32;
    localparam int SqSteps  = 32;
    localparam int SqRemW   = 36;
    localparam int OneShift = 30;
    localparam int QW       = 31;
    localparam int DivSteps = 31;
    localparam int NumW     = 1 + NormW + OneShift;
    localparam int OutW     = 32;
    localparam int PreStages  = 5;
    localparam int BackStages = PreStages + (SqSteps + 1) + (DivSteps + 1) + 1;

    typedef struct packed {
        logic [2:0][CrossW-1:0] n;
        logic                   deg;
    } cross_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tun_if.sv =====
// Request channels of the unit normal block: vertex triangle in, unit normal out.
`default_nettype none
interface tun_vtx_if;
    import tun_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tun_nrm_if;
    import tun_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [OutW-1:0] nx;
    logic signed [OutW-1:0] ny;
    logic signed [OutW-1:0] nz;
    logic                   degenerate;

    modport source (output valid, nx, ny, nz, degenerate, input ready);
    modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tun_front.sv =====
// Front end: edge vectors, cross product and degenerate classification in three stages.
`default_nettype none
module tun_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    tun_vtx_if.sink             vtx,
    output logic                cr_valid,
    input  wire logic           cr_ready,
    output tun_pkg::cross_t     cr
);
    import tun_pkg::*;

    logic [2:0]                vld_reg;
    logic                      en;
    logic signed [EdgeW-1:0]   u_reg [3];
    logic signed [EdgeW-1:0]   v_reg [3];
    logic signed [EdgeW-1:0]   u_next [3];
    logic signed [EdgeW-1:0]   v_next [3];
    logic signed [ProdW-1:0]   p_reg [6];
    logic signed [ProdW-1:0]   p_next [6];
    logic signed [CrossW-1:0]  n_next [3];
    cross_t                    cr_reg;
    cross_t                    cr_next;

    assign en        = !vld_reg[2] || cr_ready;
    assign vtx.ready = en;
    assign cr_valid  = vld_reg[2];
    assign cr        = cr_reg;

    always_comb
    begin
        u_next[0] = {vtx.ax[CoordW-1], vtx.ax} - {vtx.cx[CoordW-1], vtx.cx};
        u_next[1] = {vtx.ay[CoordW-1], vtx.ay} - {vtx.cy[CoordW-1], vtx.cy};
        u_next[2] = {vtx.az[CoordW-1], vtx.az} - {vtx.cz[CoordW-1], vtx.cz};
        v_next[0] = {vtx.bx[CoordW-1], vtx.bx} - {vtx.cx[CoordW-1], vtx.cx};
        v_next[1] = {vtx.by_coord[CoordW-1], vtx.by_coord} - {vtx.cy[CoordW-1], vtx.cy};
        v_next[2] = {vtx.bz[CoordW-1], vtx.bz} - {vtx.cz[CoordW-1], vtx.cz};

        p_next[0] = u_reg[1] * v_reg[2];
        p_next[1] = v_reg[1] * u_reg[2];
        p_next[2] = v_reg[0] * u_reg[2];
        p_next[3] = u_reg[0] * v_reg[2];
        p_next[4] = u_reg[0] * v_reg[1];
        p_next[5] = v_reg[0] * u_reg[1];

        // Each component stays below 2^49 in magnitude, so 50 bits hold it exactly.
        n_next[0] = p_reg[0] - p_reg[1];
        n_next[1] = p_reg[2] - p_reg[3];
        n_next[2] = p_reg[4] - p_reg[5];

        cr_next.n[0] = n_next[0];
        cr_next.n[1] = n_next[1];
        cr_next.n[2] = n_next[2];
        cr_next.deg  = (n_next[0] == '0) && (n_next[1] == '0) && (n_next[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], vtx.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= u_next[i];
                v_reg[i] <= v_next[i];
            end
            for (int j = 0; j < 6; j++)
            begin
                p_reg[j] <= p_next[j];
            end
            cr_reg <= cr_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tun_queue.sv =====
// Small first-in first-out queue of cross products between front and back end.
`default_nettype none
module tun_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tun_pkg::cross_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tun_pkg::cross_t      out_data
);
    import tun_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cross_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tun_back.sv =====
// Back end: normalisation, squared length, square root and division, one step per stage.
`default_nettype none
module tun_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tun_pkg::cross_t in_data,
    tun_nrm_if.source            nrm
);
    import tun_pkg::*;

    logic [BackStages-1:0] valid_reg;
    logic                  en;

    // Pre-processing stages.
    logic [CrossW-1:0]      mag_full [3];
    logic [MagW-1:0]        m1_reg [3];
    logic [MagW-1:0]        or1_reg;
    logic [2:0]             neg1_reg;
    logic                   deg1_reg;
    logic [MagW-1:0]        m2_reg [3];
    logic [NumGrp-1:0]      gnz2_reg;
    logic [GposW-1:0]       gpos2_reg [NumGrp];
    logic [GposW-1:0]       gpos_next [NumGrp];
    logic [2:0]             neg2_reg;
    logic                   deg2_reg;
    logic [MagW-1:0]        m3_reg [3];
    logic [LenW-1:0]        len;
    logic [LenW-1:0]        lz3_reg;
    logic [2:0]             neg3_reg;
    logic                   deg3_reg;
    logic [MagW-1:0]        sh [3];
    logic [NormW-1:0]       s4_reg [3];
    logic [2:0]             neg4_reg;
    logic                   deg4_reg;
    logic [SqrW-1:0]        sqr5_reg [3];
    logic [NormW-1:0]       s5_reg [3];
    logic [2:0]             neg5_reg;
    logic                   deg5_reg;

    // Square root stages.
    logic [SqRemW-1:0]      sq_rem_reg  [SqSteps+1];
    logic [RootW-1:0]       sq_root_reg [SqSteps+1];
    logic [SumW-1:0]        sq_src_reg  [SqSteps+1];
    logic [NormW-1:0]       sq_s_reg    [SqSteps+1][3];
    logic [2:0]             sq_neg_reg  [SqSteps+1];
    logic                   sq_deg_reg  [SqSteps+1];
    logic [SqRemW-1:0]      sq_shift    [SqSteps];
    logic [SqRemW-1:0]      sq_trial    [SqSteps];
    logic [SqRemW-1:0]      sq_rem_next [SqSteps];
    logic [RootW-1:0]       sq_root_next[SqSteps];

    // Division stages.
    logic [NumW-1:0]        num [3];
    logic [RootW-1:0]       dv_rem_reg [DivSteps+1][3];
    logic [QW-1:0]          dv_lo_reg  [DivSteps+1][3];
    logic [QW-1:0]          dv_q_reg   [DivSteps+1][3];
    logic [RootW-1:0]       dv_r_reg   [DivSteps+1];
    logic [2:0]             dv_neg_reg [DivSteps+1];
    logic                   dv_deg_reg [DivSteps+1];
    logic [RootW:0]         dv_shift   [DivSteps][3];
    logic [RootW-1:0]       dv_rem_next[DivSteps][3];
    logic                   dv_bit     [DivSteps][3];

    // Output stage.
    logic [OutW-1:0]        q_ext [3];
    logic [OutW-1:0]        out_next [3];
    logic [OutW-1:0]        out_reg [3];
    logic                   deg_out_reg;

    assign en         = !valid_reg[BackStages-1] || nrm.ready;
    assign in_ready   = en;
    assign nrm.valid  = valid_reg[BackStages-1];
    assign nrm.nx     = out_reg[0];
    assign nrm.ny     = out_reg[1];
    assign nrm.nz     = out_reg[2];
    assign nrm.degenerate = deg_out_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_full[i] = in_data.n[i][CrossW-1] ? ('0 - in_data.n[i]) : in_data.n[i];
        end

        // Highest set bit inside each seven-bit group of the OR of the magnitudes.
        for (int g = 0; g < NumGrp; g++)
        begin
            gpos_next[g] = '0;
            for (int j = 0; j < GrpW; j++)
            begin
                if (or1_reg[g*GrpW + j])
                begin
                    gpos_next[g] = GposW'(j);
                end
            end
        end

        len = '0;
        for (int g = 0; g < NumGrp; g++)
        begin
            if (gnz2_reg[g])
            begin
                len = LenW'(g*GrpW + 1) + LenW'(gpos2_reg[g]);
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            sh[i] = m3_reg[i] << lz3_reg;
        end

        for (int k = 0; k < SqSteps; k++)
        begin
            sq_trial[k] = {2'b00, sq_root_reg[k], 2'b01};
            sq_shift[k] = {sq_rem_reg[k][SqRemW-3:0], sq_src_reg[k][SumW-1 -: 2]};
            if (sq_shift[k] >= sq_trial[k])
            begin
                sq_rem_next[k]  = sq_shift[k] - sq_trial[k];
                sq_root_next[k] = {sq_root_reg[k][RootW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = sq_shift[k];
                sq_root_next[k] = {sq_root_reg[k][RootW-2:0], 1'b0};
            end
        end

        // Numerator s * 2^30 + floor(r / 2) gives division rounded half up.
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {1'b0, sq_s_reg[SqSteps][i], {OneShift{1'b0}}}
                   + NumW'(sq_root_reg[SqSteps] >> 1);
        end

        for (int k = 0; k < DivSteps; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_shift[k][i] = {dv_rem_reg[k][i], dv_lo_reg[k][i][QW-1]};
                dv_bit[k][i]   = (dv_shift[k][i] >= {1'b0, dv_r_reg[k]});
                if (dv_bit[k][i])
                begin
                    dv_rem_next[k][i] = RootW'(dv_shift[k][i] - {1'b0, dv_r_reg[k]});
                end
                else
                begin
                    dv_rem_next[k][i] = dv_shift[k][i][RootW-1:0];
                end
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            q_ext[i] = {1'b0, dv_q_reg[DivSteps][i]};
            if (dv_deg_reg[DivSteps])
            begin
                out_next[i] = '0;
            end
            else if (dv_neg_reg[DivSteps][i])
            begin
                out_next[i] = '0 - q_ext[i];
            end
            else
            begin
                out_next[i] = q_ext[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[BackStages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i]   <= mag_full[i][MagW-1:0];
                neg1_reg[i] <= in_data.n[i][CrossW-1];
            end
            or1_reg  <= mag_full[0][MagW-1:0] | mag_full[1][MagW-1:0]
                      | mag_full[2][MagW-1:0];
            deg1_reg <= in_data.deg;

            for (int g = 0; g < NumGrp; g++)
            begin
                gnz2_reg[g]  <= |or1_reg[g*GrpW +: GrpW];
                gpos2_reg[g] <= gpos_next[g];
            end
            m2_reg   <= m1_reg;
            neg2_reg <= neg1_reg;
            deg2_reg <= deg1_reg;

            lz3_reg  <= LenW'(MagW) - len;
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
            deg3_reg <= deg2_reg;

            for (int i = 0; i < 3; i++)
            begin
                s4_reg[i] <= sh[i][MagW-1:NormLsb];
            end
            neg4_reg <= neg3_reg;
            deg4_reg <= deg3_reg;

            for (int i = 0; i < 3; i++)
            begin
                sqr5_reg[i] <= s4_reg[i] * s4_reg[i];
            end
            s5_reg   <= s4_reg;
            neg5_reg <= neg4_reg;
            deg5_reg <= deg4_reg;

            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_src_reg[0]  <= SumW'(sqr5_reg[0]) + SumW'(sqr5_reg[1]) + SumW'(sqr5_reg[2]);
            sq_s_reg[0]    <= s5_reg;
            sq_neg_reg[0]  <= neg5_reg;
            sq_deg_reg[0]  <= deg5_reg;
            for (int k = 0; k < SqSteps; k++)
            begin
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_src_reg[k+1]  <= sq_src_reg[k] << 2;
                sq_s_reg[k+1]    <= sq_s_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
                sq_deg_reg[k+1]  <= sq_deg_reg[k];
            end

            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= {1'b0, num[i][NumW-1:DivSteps]};
                dv_lo_reg[0][i]  <= num[i][DivSteps-1:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_r_reg[0]   <= sq_root_reg[SqSteps];
            dv_neg_reg[0] <= sq_neg_reg[SqSteps];
            dv_deg_reg[0] <= sq_deg_reg[SqSteps];
            for (int k = 0; k < DivSteps; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[k+1][i] <= dv_rem_next[k][i];
                    dv_lo_reg[k+1][i]  <= dv_lo_reg[k][i] << 1;
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][QW-2:0], dv_bit[k][i]};
                end
                dv_r_reg[k+1]   <= dv_r_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_deg_reg[k+1] <= dv_deg_reg[k];
            end

            out_reg     <= out_next;
            deg_out_reg <= dv_deg_reg[DivSteps];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/triangle_unit_normal_unit.sv =====
// Top level of the triangle unit normal block: front end, queue and back end.
// Throughput is one triangle per cycle while results are taken; the 32 square-root and 31 divider stages set the depth.
// The front end and back end each stall as a whole when their downstream side is full.
// Reset (rst_n, asynchronous, active low) clears valid bits, queue pointers and queue count only.
`default_nettype none
module triangle_unit_normal_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tun_vtx_if.sink   vtx,
    tun_nrm_if.source nrm
);
    import tun_pkg::*;

    // Front end to queue.
    logic   fr_valid;
    logic   fr_ready;
    cross_t fr_data;

    // Queue to back end.
    logic   bk_valid;
    logic   bk_ready;
    cross_t bk_data;

    // The front end forms the edges and the exact cross product, and marks a
    // triangle whose cross product is the zero vector as degenerate.
    tun_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx      (vtx),
        .cr_valid (fr_valid),
        .cr_ready (fr_ready),
        .cr       (fr_data)
    );

    // The queue lets the front end keep accepting requests while the back end
    // is held by a stalled result.
    tun_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    // The back end scales the magnitudes to 31 bits, takes the integer square
    // root of their squared sum and divides each by it with rounding; its last
    // stage is the output register.
    tun_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bk_valid),
        .in_ready (bk_ready),
        .in_data  (bk_data),
        .nrm      (nrm)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/tun_chk.sv =====
// Checker on the result channel of the unit normal block, with its bind statement.
`default_nettype none
`include "triangle_unit_normal_unit_defines.svh"
module tun_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               valid,
    input wire logic               ready,
    input wire logic signed [31:0] nx,
    input wire logic signed [31:0] ny,
    input wire logic signed [31:0] nz,
    input wire logic               degenerate
);
    localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

    `TUN_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable(nx) && $stable(degenerate), "stalled result changed")
    `TUN_ASSERT_IMPL(a_degen_zero, valid && degenerate, nx == 0 && ny == 0 && nz == 0, "degenerate result with non-zero normal")
    `TUN_ASSERT_IMPL(a_normal_nonzero, valid && !degenerate, nx != 0 || ny != 0 || nz != 0, "zero normal without degenerate flag")
    `TUN_ASSERT_IMPL(a_range, valid, nx >= -OneQ30 && nx <= OneQ30 && ny >= -OneQ30 && ny <= OneQ30 && nz >= -OneQ30 && nz <= OneQ30, "normal component out of range")
endmodule

bind triangle_unit_normal_unit tun_chk u_tun_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (nrm.valid),
    .ready      (nrm.ready),
    .nx         (nrm.nx),
    .ny         (nrm.ny),
    .nz         (nrm.nz),
    .degenerate (nrm.degenerate)
);
`default_nettype wire

// ===== test/tb_tun_scoreboard.sv =====
// Unit normal predictor and scoreboard class for the triangle unit normal testbench.
package tb_tun_sb_pkg;
    import tun_pkg::*;

    typedef struct {
        logic signed [OutW-1:0] nx;
        logic signed [OutW-1:0] ny;
        logic signed [OutW-1:0] nz;
        logic                   degenerate;
    } normal_t;

    function automatic logic [31:0] floor_root(logic [63:0] sq);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > sq)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (sq >= root + bitv)
            begin
                sq = sq - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    function automatic normal_t unit_normal(logic signed [23:0] a[3], logic signed [23:0] b[3],
                                            logic signed [23:0] c[3]);
        normal_t res;
        logic signed [63:0] u[3];
        logic signed [63:0] v[3];
        logic signed [63:0] cr[3];
        logic [63:0] mag[3];
        logic [63:0] maxm;
        logic [63:0] sum;
        logic [63:0] root;
        logic [95:0] q;
        int blen;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = 64'(a[i]) - 64'(c[i]);
            v[i] = 64'(b[i]) - 64'(c[i]);
        end
        cr[0] = u[1] * v[2] - v[1] * u[2];
        cr[1] = v[0] * u[2] - u[0] * v[2];
        cr[2] = u[0] * v[1] - v[0] * u[1];
        maxm = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (mag[i] > maxm)
                maxm = mag[i];
        end
        res.degenerate = (maxm == 0);
        res.nx = 0;
        res.ny = 0;
        res.nz = 0;
        if (maxm == 0)
            return res;
        blen = 0;
        while ((maxm >> blen) != 0)
            blen++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = blen > 31 ? mag[i] >> (blen - 31) : mag[i] << (31 - blen);
            sum += mag[i] * mag[i];
        end
        root = {32'd0, floor_root(sum)};
        for (int i = 0; i < 3; i++)
        begin
            q = ((96'(mag[i]) << 30) + 96'(root >> 1)) / 96'(root);
            if (cr[i] < 0)
                q = -q;
            if (i == 0) res.nx = q[31:0];
            else if (i == 1) res.ny = q[31:0];
            else res.nz = q[31:0];
        end
        return res;
    endfunction

    class normal_scoreboard;
        normal_t pending[$];
        int mismatches = 0;

        function void note_triangle(logic signed [23:0] a[3], logic signed [23:0] b[3],
                                    logic signed [23:0] c[3]);
            pending.push_back(unit_normal(a, b, c));
        endfunction

        function void check_normal(normal_t got);
            normal_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected normal %0d %0d %0d deg %0b", got.nx, got.ny, got.nz,
                             got.degenerate);
                return;
            end
            want = pending.pop_front();
            if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                got.degenerate !== want.degenerate)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Normal mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                             want.nx, want.ny, want.nz, want.degenerate,
                             got.nx, got.ny, got.nz, got.degenerate);
            end
        endfunction
    endclass
endpackage

// ===== test/tb.sv =====
// Top-level testbench of the triangle unit normal block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tun_pkg::*;
    import tb_tun_sb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sending_done = 1'b0;
    logic hold_off = 1'b0;

    tun_vtx_if vtx();
    tun_nrm_if nrm();

    triangle_unit_normal_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx.sink),
        .nrm   (nrm.source)
    );

    normal_scoreboard board = new();

    always #4 clk = ~clk;

    // Draws a coordinate: mostly modest values, sometimes the field extremes, small offsets or full-range values.
    function automatic logic signed [23:0] draw_coord();
        case ($urandom_range(0, 9))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return 24'($urandom_range(0, 15)) - 24'sd8;
            3, 4: return 24'($urandom);
            default: return 24'($urandom_range(0, 65535)) - 24'sd32768;
        endcase
    endfunction

    // Offers one triangle request and holds it until the block accepts it.
    // Valid is dropped only for an idle gap, so back-to-back requests keep it high.
    task automatic send_triangle(logic signed [23:0] a[3], logic signed [23:0] b[3],
                                 logic signed [23:0] c[3]);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx.ax <= a[0];
        vtx.ay <= a[1];
        vtx.az <= a[2];
        vtx.bx <= b[0];
        vtx.by_coord <= b[1];
        vtx.bz <= b[2];
        vtx.cx <= c[0];
        vtx.cy <= c[1];
        vtx.cz <= c[2];
        vtx.valid <= 1'b1;
        do
            @(posedge clk);
        while (!vtx.ready);
        // The request is accepted at this edge, so note it.
        board.note_triangle(a, b, c);
    endtask

    // Directed triangles: extremes, degenerate shapes and axis-aligned cases, then random ones.
    initial
    begin
        logic signed [23:0] a[3];
        logic signed [23:0] b[3];
        logic signed [23:0] c[3];
        int k;
        vtx.valid = 1'b0;
        {vtx.ax, vtx.ay, vtx.az, vtx.bx, vtx.by_coord, vtx.bz, vtx.cx, vtx.cy, vtx.cz} = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // All vertices coincident gives a degenerate triangle.
        a = '{0, 0, 0}; b = '{0, 0, 0}; c = '{0, 0, 0};
        send_triangle(a, b, c);
        // Collinear vertices are degenerate as well.
        a = '{24'sd4096, 24'sd8192, 24'sd12288}; b = '{24'sd8192, 24'sd16384, 24'sd24576};
        send_triangle(a, b, c);
        // Unit triangles in each plane give normals along the axes.
        a = '{24'sd4096, 0, 0}; b = '{0, 24'sd4096, 0};
        send_triangle(a, b, c);
        send_triangle(b, a, c);
        a = '{0, 24'sd4096, 0}; b = '{0, 0, 24'sd4096};
        send_triangle(a, b, c);
        a = '{0, 0, 24'sd4096}; b = '{24'sd4096, 0, 0};
        send_triangle(a, b, c);
        // Tiny cross product needs a large left shift.
        a = '{24'sd1, 0, 0}; b = '{0, 24'sd1, 0};
        send_triangle(a, b, c);
        // Extreme coordinates make the largest edges and cross products.
        a = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
        b = '{24'sh800000, 24'sh7FFFFF, 24'sh800000};
        c = '{24'sh800000, 24'sh800000, 24'sh7FFFFF};
        send_triangle(a, b, c);
        a = '{24'sh7FFFFF, 24'sh800000, 24'sh800000};
        b = '{24'sh800000, 24'sh7FFFFF, 24'sh800000};
        c = '{24'sh800000, 24'sh800000, 24'sh7FFFFF};
        send_triangle(a, b, c);
        a = '{24'sh800000, 24'sh800000, 24'sh800000};
        b = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
        c = '{24'sh7FFFFF, 24'sh800000, 24'sh800000};
        send_triangle(a, b, c);
        a = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
        b = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
        send_triangle(a, b, c);
        // Equal-magnitude components exercise rounding of the division.
        a = '{24'sd4096, 24'sd4096, 0}; b = '{0, 24'sd4096, 24'sd4096};
        c = '{24'sd4096, 0, 24'sd4096};
        send_triangle(a, b, c);
        for (k = 0; k < 1940; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a[i] = draw_coord();
                b[i] = draw_coord();
                c[i] = draw_coord();
            end
            // Some triangles are made degenerate by repeating or mirroring a vertex.
            if ($urandom_range(0, 19) == 0)
                b = a;
            else if ($urandom_range(0, 19) == 0)
                for (int i = 0; i < 3; i++)
                    b[i] = c[i] - (a[i] - c[i]);
            send_triangle(a, b, c);
        end
        vtx.valid <= 1'b0;
        sending_done <= 1'b1;
    end

    // Receiver: random stalls, and one long hold-off so the block fills and stops taking requests.
    initial
    begin
        nrm.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                nrm.ready <= 1'b0;
            else
                nrm.ready <= ($urandom_range(0, 4) == 0) ? 1'b0 : 1'b1;
        end
    end

    initial
    begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Check each normal accepted at a clock edge.
    always @(posedge clk)
    begin
        normal_t got;
        if (rst_n && nrm.valid && nrm.ready)
        begin
            got.nx = nrm.nx;
            got.ny = nrm.ny;
            got.nz = nrm.nz;
            got.degenerate = nrm.degenerate;
            board.check_normal(got);
        end
    end

    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tun_pkg.sv
hw/rtl/tun_if.sv
hw/rtl/tun_front.sv
hw/rtl/tun_queue.sv
hw/rtl/tun_back.sv
hw/rtl/triangle_unit_normal_unit.sv
hw/rtl/tun_chk.sv
test/tb_tun_scoreboard.sv
test/tb.sv
